// ----- src/mpq_pkg.sv -----
// Package: shared types and constants for the min priority queue.
`default_nettype none

package mpq_pkg;

    localparam int KEY_W   = 32;
    localparam int COUNT_W = 7;

    typedef enum logic [1:0] {
        FUNC_INSERT  = 2'd0,
        FUNC_PEEK    = 2'd1,
        FUNC_EXTRACT = 2'd2,
        FUNC_CLEAR   = 2'd3
    } t_func;

    typedef enum logic [1:0] {
        STATUS_OK    = 2'd0,
        STATUS_EMPTY = 2'd1,
        STATUS_FULL  = 2'd2
    } t_status;

    // Broadcast to every cell in the chain.
    typedef struct packed {
        logic                    do_insert;
        logic                    do_extract;
        logic                    do_clear;
        logic signed [KEY_W-1:0] key;
    } t_cell_ctrl;

endpackage

`default_nettype wire

// ----- src/mpq_if.sv -----
// Interfaces: operation input, result output and mode register write channels.
`default_nettype none

interface mpq_in_if;
    import mpq_pkg::*;
    logic                    valid;
    logic                    ready;
    t_func                   func;
    logic signed [KEY_W-1:0] key_in;

    modport source (output valid, output func, output key_in, input ready);
    modport sink   (input valid, input func, input key_in, output ready);
endinterface

interface mpq_out_if;
    import mpq_pkg::*;
    logic                    valid;
    logic                    ready;
    logic signed [KEY_W-1:0] min_key;
    t_status                 status;
    logic [COUNT_W-1:0]      entry_count;

    modport source (output valid, output min_key, output status, output entry_count,
                    input ready);
    modport sink   (input valid, input min_key, input status, input entry_count,
                    output ready);
endinterface

interface mpq_cfg_if;
    logic valid;
    logic ready;
    logic sorted_mode;

    modport source (output valid, output sorted_mode, input ready);
    modport sink   (input valid, input sorted_mode, output ready);
endinterface

`default_nettype wire

// ----- src/min_priority_queue.sv -----
// Top level: bounded min priority queue built as a chain of sorting cells.
`default_nettype none

// Bounded min priority queue of signed 32-bit keys, held in a row of CAPACITY
// cells kept in ascending order at all times, smallest key in cell 0. Each input
// transaction carries an operation (insert, peek, extract, clear) and a key; each
// produces exactly one result transaction with the minimum key (peek/extract),
// a status (ok, empty, full) and the count held after the operation.
// Timing: one transaction is accepted per cycle; its result appears in the output
// register on the next cycle. Every cell compares its key with the incoming key
// in parallel and loads from a neighbor, so insert, extract and clear all finish
// in the same cycle. Input ready drops only while a result waits in the output
// register and the sink is not taking it. The sorted_mode register is accepted at
// any time (ready tied high); the chain always keeps keys ascending, which gives
// the same results in either mode. No clearing pass after reset is needed.
// entry_count shows the low 7 bits of the count.
module min_priority_queue #(
    parameter int CAPACITY = 64
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    mpq_in_if.sink     i_in,
    mpq_out_if.source  o_out,
    mpq_cfg_if.sink    i_cfg
);
    import mpq_pkg::*;

    localparam int CNT_W = $clog2(CAPACITY + 1);

    // Mode register
    logic r_sorted_mode;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sorted_mode <= 1'b1;
        end else if (i_cfg.valid && i_cfg.ready) begin
            r_sorted_mode <= i_cfg.sorted_mode;
        end
    end

    assign i_cfg.ready = 1'b1;

    // Count and handshake
    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;
    logic             w_accept;
    logic             w_full;
    logic             w_empty;
    t_cell_ctrl       w_ctrl;

    logic                    r_out_valid;
    logic signed [KEY_W-1:0] r_min_key;
    logic signed [KEY_W-1:0] n_min_key;
    t_status                 r_status;
    t_status                 n_status;
    logic [COUNT_W-1:0]      r_entry_count;

    // Cell chain nets
    logic [CAPACITY-1:0]     w_valid;
    logic [CAPACITY-1:0]     w_keep;
    logic signed [KEY_W-1:0] w_key [CAPACITY];

    assign i_in.ready = !r_out_valid || o_out.ready;
    assign w_accept   = i_in.valid && i_in.ready;
    assign w_full     = (r_count == CNT_W'(CAPACITY));
    assign w_empty    = (r_count == '0);

    always_comb begin
        w_ctrl.do_insert  = w_accept && (i_in.func == FUNC_INSERT) && !w_full;
        w_ctrl.do_extract = w_accept && (i_in.func == FUNC_EXTRACT) && !w_empty;
        w_ctrl.do_clear   = w_accept && (i_in.func == FUNC_CLEAR);
        w_ctrl.key        = i_in.key_in;
    end

    // Result for the current operation
    always_comb begin
        n_count   = r_count;
        n_min_key = '0;
        n_status  = STATUS_OK;
        case (i_in.func)
            FUNC_INSERT: begin
                if (w_full) begin
                    n_status = STATUS_FULL;
                end else begin
                    n_count = r_count + 1'b1;
                end
            end
            FUNC_PEEK: begin
                if (w_empty) begin
                    n_status = STATUS_EMPTY;
                end else begin
                    n_min_key = w_key[0];
                end
            end
            FUNC_EXTRACT: begin
                if (w_empty) begin
                    n_status = STATUS_EMPTY;
                end else begin
                    n_min_key = w_key[0];
                    n_count   = r_count - 1'b1;
                end
            end
            FUNC_CLEAR: begin
                n_count = '0;
            end
            default: begin
                n_count = r_count;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_accept) begin
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Result payload, no reset needed
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_min_key     <= n_min_key;
            r_status      <= n_status;
            r_entry_count <= COUNT_W'(n_count);
        end
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.min_key     = r_min_key;
    assign o_out.status      = r_status;
    assign o_out.entry_count = r_entry_count;

    // Cell chain: cell 0 has a virtual always-keeping left neighbor, the last
    // cell an always-empty right neighbor.
    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic                    w_lv;
        logic                    w_lk;
        logic signed [KEY_W-1:0] w_lkey;
        logic                    w_rv;
        logic signed [KEY_W-1:0] w_rkey;

        if (g == 0) begin : g_first
            assign w_lv   = 1'b1;
            assign w_lk   = 1'b1;
            assign w_lkey = '0;
        end else begin : g_mid
            assign w_lv   = w_valid[g-1];
            assign w_lk   = w_keep[g-1];
            assign w_lkey = w_key[g-1];
        end

        if (g == CAPACITY - 1) begin : g_last
            assign w_rv   = 1'b0;
            assign w_rkey = '0;
        end else begin : g_inner
            assign w_rv   = w_valid[g+1];
            assign w_rkey = w_key[g+1];
        end

        mpq_cell u_cell (
            .i_clk         (i_clk),
            .i_rst_n       (i_rst_n),
            .i_ctrl        (w_ctrl),
            .i_left_valid  (w_lv),
            .i_left_keep   (w_lk),
            .i_left_key    (w_lkey),
            .i_right_valid (w_rv),
            .i_right_key   (w_rkey),
            .o_valid       (w_valid[g]),
            .o_keep        (w_keep[g]),
            .o_key         (w_key[g])
        );
    end

`ifndef SYNTHESIS
    logic w_order_ok;

    // Occupied cells must be ascending
    always_comb begin
        w_order_ok = 1'b1;
        for (int i = 0; i < CAPACITY - 1; i++) begin
            if (w_valid[i+1] && (w_key[i+1] < w_key[i])) begin
                w_order_ok = 1'b0;
            end
        end
    end

    // Occupancy bits track the count
    a_count_matches: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(w_valid) == r_count)
        else $error("cell occupancy disagrees with count");

    a_sorted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sorted_mode |-> w_order_ok)
        else $error("cell chain out of order");

    // A full insert reports full status and leaves the count at capacity
    a_full_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept && (i_in.func == FUNC_INSERT) && w_full |=>
            (r_status == STATUS_FULL) && (r_count == CNT_W'(CAPACITY)))
        else $error("full insert mishandled");
`endif

endmodule

`default_nettype wire

// ----- src/mpq_cell.sv -----
// Module: one cell of the sorted shift chain, holding a single key.
`default_nettype none

module mpq_cell (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire mpq_pkg::t_cell_ctrl             i_ctrl,
    input  wire logic                            i_left_valid,
    input  wire logic                            i_left_keep,
    input  wire logic signed [mpq_pkg::KEY_W-1:0] i_left_key,
    input  wire logic                            i_right_valid,
    input  wire logic signed [mpq_pkg::KEY_W-1:0] i_right_key,
    output logic                                 o_valid,
    output logic                                 o_keep,
    output logic signed [mpq_pkg::KEY_W-1:0]     o_key
);
    import mpq_pkg::*;

    logic                    r_valid;
    logic                    n_valid;
    logic signed [KEY_W-1:0] r_key;
    logic signed [KEY_W-1:0] n_key;
    logic                    w_keep;

    // Key stays put on insert when it is strictly below the new key.
    assign w_keep = r_valid && (r_key < i_ctrl.key);

    always_comb begin
        n_valid = r_valid;
        n_key   = r_key;
        if (i_ctrl.do_clear) begin
            n_valid = 1'b0;
        end else if (i_ctrl.do_insert) begin
            n_valid = r_valid | i_left_valid;
            if (!w_keep) begin
                n_key = i_left_keep ? i_ctrl.key : i_left_key;
            end
        end else if (i_ctrl.do_extract) begin
            n_valid = i_right_valid;
            n_key   = i_right_key;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_key <= n_key;
    end

    assign o_valid = r_valid;
    assign o_keep  = w_keep;
    assign o_key   = r_key;

endmodule

`default_nettype wire

// ----- tb/sv/min_priority_queue_test.sv -----
// Testbench: randomized scoreboard check of the min priority queue against a built-in predictor.
`timescale 1ns / 100ps

module min_priority_queue_test;
    import mpq_pkg::*;

    localparam int CAPACITY    = 64;
    // Longest legal quiet stretch is the long receiver hold plus a random
    // gap; this leaves a wide margin.
    localparam int QUIET_LIMIT = 4000;
    localparam int HOLD_CYCLES = 400;

    typedef struct {
        t_func                   func;
        logic signed [KEY_W-1:0] key;
    } t_queue_op;

    typedef struct {
        logic signed [KEY_W-1:0] min_key;
        t_status                 status;
        logic [COUNT_W-1:0]      count;
    } t_queue_outcome;

    logic i_clk;
    logic i_rst_n;

    mpq_in_if  in_if ();
    mpq_out_if out_if ();
    mpq_cfg_if cfg_if ();

    min_priority_queue #(
        .CAPACITY(CAPACITY)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if.sink),
        .o_out   (out_if.source),
        .i_cfg   (cfg_if.sink)
    );

    // Shadow copy of the queue contents, laid out sorted or in arrival order
    // as the mode says; duplicate minima are equal keys, so any copy gives the same result.
    logic signed [KEY_W-1:0] model_keys [0:CAPACITY-1];
    int                      model_count = 0;
    bit                      model_sorted = 1'b1;

    t_queue_op      ops_to_send [$];   // operations not yet offered to the block
    t_queue_outcome outcomes_due [$];  // predicted results, oldest first
    t_queue_op      next_op;

    int  mismatches  = 0;
    int  quiet_count = 0;
    bit  in_taken    = 1'b0;   // input transaction completed at the last rising edge
    bit  idle_en     = 1'b0;   // random idle bursts allowed on both sides
    bit  sender_pause = 1'b0;
    bit  hold_start  = 1'b0;   // request for a long receiver hold-off
    int  hold_left   = 0;
    int  tx_gap      = 0;
    int  rx_gap      = 0;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Apply one operation to the shadow queue and return the result the
    // block must produce for it.
    function automatic t_queue_outcome apply_queue_op(t_func f, logic signed [KEY_W-1:0] k);
        t_queue_outcome r;
        int pos;
        int best;
        int i;
        r.min_key = '0;
        r.status  = STATUS_OK;
        case (f)
            FUNC_INSERT: begin
                if (model_count >= CAPACITY) begin
                    r.status = STATUS_FULL;
                end else begin
                    pos = model_count;
                    if (model_sorted) begin
                        // first slot not below the new key
                        for (i = 0; i < model_count; i++) begin
                            if (!(model_keys[i] < k)) begin
                                pos = i;
                                break;
                            end
                        end
                        for (i = model_count; i > pos; i--)
                            model_keys[i] = model_keys[i-1];
                    end
                    model_keys[pos] = k;
                    model_count++;
                end
            end
            FUNC_PEEK, FUNC_EXTRACT: begin
                if (model_count == 0) begin
                    r.status = STATUS_EMPTY;
                end else begin
                    // full scan; strict compare keeps the lowest-indexed duplicate
                    best = 0;
                    for (i = 1; i < model_count; i++)
                        if (model_keys[i] < model_keys[best])
                            best = i;
                    r.min_key = model_keys[best];
                    if (f == FUNC_EXTRACT) begin
                        for (i = best; i + 1 < model_count; i++)
                            model_keys[i] = model_keys[i+1];
                        model_count--;
                    end
                end
            end
            default: begin
                model_count = 0;
            end
        endcase
        r.count = COUNT_W'(model_count);
        return r;
    endfunction

    // Rising edge: score the result transaction, then predict for the input
    // transaction. Results are registered after their input is accepted, so checking
    // first never pairs a result with the item accepted at the same edge.
    always @(posedge i_clk) begin
        t_queue_outcome want;
        in_taken = 1'b0;
        if (i_rst_n) begin
            if (out_if.valid === 1'b1 && out_if.ready === 1'b1) begin
                quiet_count = 0;
                if (outcomes_due.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result: min_key %0d status %0d count %0d",
                                 out_if.min_key, out_if.status, out_if.entry_count);
                end else begin
                    want = outcomes_due.pop_front();
                    if (out_if.min_key !== want.min_key || out_if.status !== want.status ||
                        out_if.entry_count !== want.count) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: min_key %0d/%0d status %0d/%0d count %0d/%0d",
                                     want.min_key, out_if.min_key, want.status,
                                     out_if.status, want.count, out_if.entry_count);
                    end
                end
            end else begin
                quiet_count++;
            end
            if (in_if.valid === 1'b1 && in_if.ready === 1'b1) begin
                in_taken    = 1'b1;
                quiet_count = 0;
                outcomes_due.push_back(apply_queue_op(in_if.func, in_if.key_in));
            end
            if (quiet_count >= QUIET_LIMIT) begin
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    // Input driver: a new transaction goes out only once the previous one
    // has completed or none was offered.
    always @(negedge i_clk) begin
        if (i_rst_n && (!in_if.valid || in_taken)) begin
            if (tx_gap > 0) begin
                tx_gap--;
                in_if.valid <= 1'b0;
            end else if (ops_to_send.size() != 0 && !sender_pause) begin
                next_op = ops_to_send.pop_front();
                in_if.valid  <= 1'b1;
                in_if.func   <= next_op.func;
                in_if.key_in <= next_op.key;
                if (idle_en && $urandom_range(0, 11) == 0)
                    tx_gap = $urandom_range(1, 19);
            end else begin
                in_if.valid <= 1'b0;
            end
        end
    end

    // Result receiver: long hold-off on request, otherwise random stalls.
    always @(negedge i_clk) begin
        if (hold_start) begin
            hold_start = 1'b0;
            hold_left  = HOLD_CYCLES;
            out_if.ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            out_if.ready <= 1'b0;
        end else if (rx_gap > 0) begin
            rx_gap--;
            out_if.ready <= 1'b0;
        end else begin
            out_if.ready <= 1'b1;
            if (idle_en && $urandom_range(0, 11) == 0)
                rx_gap = $urandom_range(1, 19);
        end
    end

    function automatic logic signed [KEY_W-1:0] random_key();
        case ($urandom_range(0, 3))
            0: return KEY_W'($urandom_range(0, 15)) - 8;   // dense range, many duplicates
            1: begin
                case ($urandom_range(0, 3))
                    0: return 32'sh7fff_ffff;
                    1: return 32'sh8000_0000;
                    2: return '0;
                    default: return '1;
                endcase
            end
            default: return $urandom;
        endcase
    endfunction

    task automatic push_op(input t_func f, input logic signed [KEY_W-1:0] k);
        t_queue_op op;
        op.func = f;
        op.key  = k;
        ops_to_send.push_back(op);
    endtask

    // Fill, drain or mixed run of operations.
    task automatic push_chunk(input int kind, input int n);
        int r;
        repeat (n) begin
            r = $urandom_range(0, 99);
            case (kind)
                0: push_op(FUNC_INSERT, random_key());
                1: push_op((r < 12) ? FUNC_PEEK : FUNC_EXTRACT, $urandom);
                default: begin
                    if (r < 45)      push_op(FUNC_INSERT, random_key());
                    else if (r < 60) push_op(FUNC_PEEK, $urandom);
                    else if (r < 95) push_op(FUNC_EXTRACT, $urandom);
                    else             push_op(FUNC_CLEAR, $urandom);
                end
            endcase
        end
    endtask

    task automatic wait_sent();
        while (ops_to_send.size() != 0)
            @(posedge i_clk);
    endtask

    task automatic wait_drained();
        while (ops_to_send.size() != 0 || in_if.valid || outcomes_due.size() != 0)
            @(posedge i_clk);
    endtask

    // Mode write; the register takes it at the edge where valid meets ready.
    task automatic write_mode(input bit m);
        @(negedge i_clk);
        cfg_if.sorted_mode <= m;
        cfg_if.valid       <= 1'b1;
        do @(posedge i_clk); while (cfg_if.ready !== 1'b1);
        model_sorted = m;
        @(negedge i_clk);
        cfg_if.valid <= 1'b0;
    endtask

    initial begin
        int phase;
        int chunk;
        in_if.valid        = 1'b0;
        in_if.func         = FUNC_INSERT;
        in_if.key_in       = '0;
        out_if.ready       = 1'b0;
        cfg_if.valid       = 1'b0;
        cfg_if.sorted_mode = 1'b1;
        i_rst_n            = 1'b0;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: empty queue, key extremes, duplicate minima, clear,
        // with the reset mode (sorted) first. Keys on non-inserts are junk.
        push_op(FUNC_PEEK,    32'sh7fff_ffff);
        push_op(FUNC_EXTRACT, 32'sh8000_0000);
        push_op(FUNC_INSERT,  32'sh7fff_ffff);
        push_op(FUNC_INSERT,  32'sh8000_0000);
        push_op(FUNC_INSERT,  0);
        push_op(FUNC_INSERT,  -1);
        push_op(FUNC_INSERT,  1);
        push_op(FUNC_INSERT,  -1);
        push_op(FUNC_PEEK,    '1);
        push_op(FUNC_EXTRACT, 0);
        push_op(FUNC_EXTRACT, 0);
        push_op(FUNC_EXTRACT, 0);
        push_op(FUNC_PEEK,    0);
        push_op(FUNC_CLEAR,   32'sh5a5a_a5a5);
        push_op(FUNC_PEEK,    0);
        push_op(FUNC_INSERT,  5);
        push_op(FUNC_CLEAR,   0);
        push_op(FUNC_EXTRACT, 0);
        wait_drained();

        // Append mode: duplicates land out of order, lowest index must win.
        write_mode(1'b0);
        push_op(FUNC_INSERT,  3);
        push_op(FUNC_INSERT,  -7);
        push_op(FUNC_INSERT,  3);
        push_op(FUNC_EXTRACT, 0);
        push_op(FUNC_EXTRACT, 0);
        push_op(FUNC_PEEK,    0);
        push_op(FUNC_CLEAR,   0);
        wait_drained();

        // Random phases alternate the mode without clearing, so keys laid
        // out in one mode are scanned and extended in the other.
        for (phase = 0; phase < 4; phase++) begin
            write_mode(phase[0]);
            for (chunk = 0; chunk < 12; chunk++) begin
                // last phase runs without idling at all
                idle_en = (phase != 3) && ($urandom_range(0, 3) != 0);
                if (phase == 1 && chunk == 3)
                    hold_start = 1'b1;   // block fills up and backs off the input
                if (chunk == 0)
                    push_chunk(0, 70);   // runs into the full error
                else if (chunk == 1)
                    push_chunk(1, 70);   // drains the queue and may run into the empty error
                else
                    push_chunk(2, $urandom_range(20, 60));
                if (phase == 2 && chunk == 5) begin
                    // sender stops mid-run until every result is back
                    while (ops_to_send.size() > 10)
                        @(posedge i_clk);
                    sender_pause = 1'b1;
                    while (in_if.valid || outcomes_due.size() != 0)
                        @(posedge i_clk);
                    sender_pause = 1'b0;
                end
                wait_sent();
            end
            wait_drained();
        end

        // A short tail catches stray results.
        repeat (20) @(posedge i_clk);
        if (mismatches == 0 && outcomes_due.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
src/mpq_pkg.sv
src/mpq_if.sv
src/mpq_cell.sv
src/min_priority_queue.sv
tb/sv/min_priority_queue_test.sv
